### rtl/bond_length_histogram_unit_macros.svh
// ----------------------------------------------------------------------------
// Bond length histogram unit assertion macros
// Assertion macros shared by the histogram RTL.
// ----------------------------------------------------------------------------
`ifndef BOND_LENGTH_HISTOGRAM_UNIT_MACROS_SVH
`define BOND_LENGTH_HISTOGRAM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLH_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/blh_pkg.sv
// ----------------------------------------------------------------------------
// blh_pkg
// Types and fixed constants of the bond length histogram unit.
// ----------------------------------------------------------------------------
package blh_pkg;

  localparam int unsigned DIST_W      = 16;
  localparam int unsigned ELEM_W      = 7;
  localparam int unsigned ELEM_IDX_W  = 4;   // element numbers below the limit (at most 16)
  localparam int unsigned KEY_W       = 8;   // pair keys up to 16*16-1
  localparam int unsigned BIN_SEL_W   = 7;
  localparam int unsigned BIN_W       = 10;  // bins up to 1023
  localparam int unsigned BIN_FULL_W  = 11;  // raw bin value before the range check
  localparam int unsigned BIN_SCALE   = 100;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned PROD_W      = FRAC_BITS + BIN_FULL_W;
  localparam int unsigned TYPE_COUNT  = 4;
  localparam int unsigned TOTAL_W     = 48;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned WIDE_W      = 64;
  localparam int unsigned PAIRS_W     = 6;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  localparam logic [DIST_W-1:0]  MIN_DIST_RESET = 16'd4096;
  localparam logic [DIST_W-1:0]  MAX_DIST_RESET = 16'd8192;
  localparam logic [PAIRS_W-1:0] PAIRS_MAX      = 6'd63;

  typedef enum logic [1:0] {
    KIND_RECORD        = 2'd0,
    KIND_READ_BIN      = 2'd1,
    KIND_READ_COUNTERS = 2'd2,
    KIND_IGNORE        = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_COUNTED     = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_BAD_ELEMENT = 3'd3,
    ST_NO_TYPE     = 3'd4,
    ST_READ        = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TYPE_AROMATIC = 2'd0,
    TYPE_SINGLE   = 2'd1,
    TYPE_DOUBLE   = 2'd2,
    TYPE_TRIPLE   = 2'd3
  } bond_type_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MIN_DISTANCE = 1'b0,
    CFG_MAX_DISTANCE = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    OP_COUNT       = 3'd0,
    OP_SHORT       = 3'd1,
    OP_LONG        = 3'd2,
    OP_BAD_ELEMENT = 3'd3,
    OP_READ        = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    B_CLEAR = 2'd0,
    B_IDLE  = 2'd1,
    B_EXEC  = 2'd2
  } back_state_e;

  typedef struct packed {
    kind_e                kind;
    logic [ELEM_W-1:0]    element_a;
    logic [ELEM_W-1:0]    element_b;
    logic                 flag_aromatic;
    logic                 flag_single;
    logic                 flag_double;
    logic                 flag_triple;
    logic [DIST_W-1:0]    distance;
    logic [BIN_SEL_W-1:0] bin_select;
    logic [1:0]           type_select;
  } in_item_t;

  typedef struct packed {
    status_e                status;
    logic [OUT_COUNT_W-1:0] bin_count;
    logic                   pair_seen;
    logic [TOTAL_W-1:0]     type_total;
    logic [OUT_COUNT_W-1:0] short_count;
    logic [OUT_COUNT_W-1:0] long_count;
    logic [PAIRS_W-1:0]     pairs_seen_count;
  } out_item_t;

  // Classified work item passed from the front to the back.
  typedef struct packed {
    op_e              op;
    logic             type_hit;
    bond_type_e       sel_type;
    logic             elems_ok;
    logic             bin_ok;
    logic [KEY_W-1:0] key;
    logic [BIN_W-1:0] bin;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/blh_queue.sv
// ----------------------------------------------------------------------------
// blh_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module blh_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  blh_pkg::q_entry_t   entry_i,
  input  logic                pop_i,
  output blh_pkg::q_entry_t   head_o,
  output blh_pkg::q_status_t  status_o
);

  blh_pkg::q_entry_t                   entries_q [blh_pkg::QUEUE_DEPTH];
  logic [blh_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [blh_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [blh_pkg::QUEUE_CNT_W-1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    priority if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o         = entries_q[rd_ptr_q];
  assign status_o.full  = (count_q == blh_pkg::QUEUE_CNT_W'(blh_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

### rtl/blh_front.sv
// ----------------------------------------------------------------------------
// blh_front
// Accepts items, holds the distance window and classifies each bond.
// ----------------------------------------------------------------------------
module blh_front #(
  parameter int unsigned ELEMENT_LIMIT = 10,
  parameter int unsigned BIN_COUNT     = 101
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  blh_pkg::in_item_t                   in_item_i,
  input  logic                                cfg_we_i,
  input  logic [blh_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [blh_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                clear_busy_i,
  input  blh_pkg::q_status_t                  q_status_i,
  output logic                                push_o,
  output blh_pkg::q_entry_t                   entry_o
);

  logic [blh_pkg::DIST_W-1:0]     min_q, max_q;
  logic                           elems_ok;
  logic [blh_pkg::ELEM_IDX_W-1:0] elem_a, elem_b, elem_hi, elem_lo;
  logic [blh_pkg::DIST_W-1:0]     diff;
  logic [blh_pkg::PROD_W-1:0]     prod;
  logic [blh_pkg::BIN_FULL_W-1:0] bin_full;
  logic                           bin_fits, bsel_fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= blh_pkg::MIN_DIST_RESET;
      max_q <= blh_pkg::MAX_DIST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        blh_pkg::CFG_MIN_DISTANCE: min_q <= cfg_data_i;
        blh_pkg::CFG_MAX_DISTANCE: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_status_i.full && !clear_busy_i;
  assign push_o     = in_valid_i && in_ready_o && (in_item_i.kind != blh_pkg::KIND_IGNORE);

  assign elems_ok = (in_item_i.element_a < blh_pkg::ELEM_W'(ELEMENT_LIMIT)) &&
                    (in_item_i.element_b < blh_pkg::ELEM_W'(ELEMENT_LIMIT));
  assign elem_a   = in_item_i.element_a[blh_pkg::ELEM_IDX_W-1:0];
  assign elem_b   = in_item_i.element_b[blh_pkg::ELEM_IDX_W-1:0];
  assign elem_hi  = (elem_a > elem_b) ? elem_a : elem_b;
  assign elem_lo  = (elem_a > elem_b) ? elem_b : elem_a;

  // bin = floor((distance - min) * 100 / 4096)
  assign diff      = in_item_i.distance - min_q;
  assign prod      = blh_pkg::PROD_W'(diff) * blh_pkg::PROD_W'(blh_pkg::BIN_SCALE);
  assign bin_full  = prod[blh_pkg::FRAC_BITS +: blh_pkg::BIN_FULL_W];
  assign bin_fits  = bin_full < blh_pkg::BIN_FULL_W'(BIN_COUNT);
  assign bsel_fits = blh_pkg::BIN_FULL_W'(in_item_i.bin_select) <
                     blh_pkg::BIN_FULL_W'(BIN_COUNT);

  always_comb begin
    entry_o          = '0;
    entry_o.elems_ok = elems_ok;
    entry_o.key      = blh_pkg::KEY_W'(elem_hi * ELEMENT_LIMIT + elem_lo);

    if (in_item_i.kind == blh_pkg::KIND_RECORD) begin
      entry_o.bin    = bin_full[blh_pkg::BIN_W-1:0];
      entry_o.bin_ok = bin_fits;
      priority if (in_item_i.distance < min_q) begin
        entry_o.op = blh_pkg::OP_SHORT;
      end else if (in_item_i.distance > max_q) begin
        entry_o.op = blh_pkg::OP_LONG;
      end else if (!bin_fits) begin
        entry_o.op = blh_pkg::OP_LONG;
      end else if (!elems_ok) begin
        entry_o.op = blh_pkg::OP_BAD_ELEMENT;
      end else begin
        entry_o.op = blh_pkg::OP_COUNT;
      end
      // first matching flag wins
      entry_o.type_hit = 1'b1;
      priority if (in_item_i.flag_aromatic) begin
        entry_o.sel_type = blh_pkg::TYPE_AROMATIC;
      end else if (in_item_i.flag_single) begin
        entry_o.sel_type = blh_pkg::TYPE_SINGLE;
      end else if (in_item_i.flag_double) begin
        entry_o.sel_type = blh_pkg::TYPE_DOUBLE;
      end else if (in_item_i.flag_triple) begin
        entry_o.sel_type = blh_pkg::TYPE_TRIPLE;
      end else begin
        entry_o.sel_type = blh_pkg::TYPE_AROMATIC;
        entry_o.type_hit = 1'b0;
      end
    end else begin
      entry_o.op       = blh_pkg::OP_READ;
      entry_o.sel_type = blh_pkg::bond_type_e'(in_item_i.type_select);
      entry_o.bin      = blh_pkg::BIN_W'(in_item_i.bin_select);
      entry_o.bin_ok   = bsel_fits;
    end
  end

endmodule

### rtl/blh_back.sv
// ----------------------------------------------------------------------------
// blh_back
// Executes classified items: histogram read-modify-write, counters, results.
// ----------------------------------------------------------------------------
`include "bond_length_histogram_unit_macros.svh"

module blh_back #(
  parameter int unsigned ELEMENT_LIMIT = 10,
  parameter int unsigned BIN_COUNT     = 101,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blh_pkg::q_status_t  q_status_i,
  input  blh_pkg::q_entry_t   head_i,
  output logic                pop_o,
  output logic                clear_busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output blh_pkg::out_item_t  out_item_o
);

  localparam int unsigned KEY_COUNT = ELEMENT_LIMIT * ELEMENT_LIMIT;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_COUNT);
  localparam int unsigned ROW_W     = KEY_IDX_W + 2;
  localparam int unsigned DEPTH     = KEY_COUNT * blh_pkg::TYPE_COUNT * BIN_COUNT;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [blh_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  blh_pkg::back_state_e state_q, state_d;

  logic [COUNT_WIDTH-1:0]          mem [DEPTH];
  logic [COUNT_WIDTH-1:0]          rd_data_q;
  logic [ADDR_W-1:0]               clr_addr_q, clr_addr_d;
  logic [ADDR_W-1:0]               addr_q, addr_d;
  logic [ADDR_W-1:0]               head_addr;
  logic [ROW_W-1:0]                head_row;
  blh_pkg::q_entry_t               ent_q, ent_d;
  logic [KEY_IDX_W-1:0]            key_idx;

  logic [KEY_COUNT-1:0]            seen_q, seen_d;
  logic [blh_pkg::TOTAL_W-1:0]     totals_q [blh_pkg::TYPE_COUNT];
  logic [blh_pkg::TOTAL_W-1:0]     totals_d [blh_pkg::TYPE_COUNT];
  logic [COUNT_WIDTH-1:0]          short_q, short_d, long_q, long_d;
  logic [blh_pkg::PAIRS_W-1:0]     pairs_q, pairs_d;
  logic [blh_pkg::PAIRS_W-1:0]     pairs_expected;

  logic                            mem_we, mem_re;
  logic [ADDR_W-1:0]               mem_waddr;
  logic [COUNT_WIDTH-1:0]          mem_wdata;
  logic                            out_free, exec_fire;

  blh_pkg::status_e                res_status;
  logic                            res_seen, res_bin_sel;
  logic [blh_pkg::TOTAL_W-1:0]     res_total;
  logic [blh_pkg::WIDE_W-1:0]      rd_wide, short_wide, long_wide;

  logic                            out_valid_q, out_valid_d;
  blh_pkg::out_item_t              out_q, out_d;

  assign head_row  = {head_i.key[KEY_IDX_W-1:0], head_i.sel_type};
  assign head_addr = ADDR_W'(head_row * BIN_COUNT + head_i.bin);
  assign key_idx   = ent_q.key[KEY_IDX_W-1:0];
  assign out_free  = !out_valid_q || out_ready_i;
  assign exec_fire = (state_q == blh_pkg::B_EXEC) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      blh_pkg::B_CLEAR: begin
        if (clr_addr_q == LAST_ADDR) begin
          state_d = blh_pkg::B_IDLE;
        end
      end
      blh_pkg::B_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = blh_pkg::B_EXEC;
        end
      end
      blh_pkg::B_EXEC: begin
        if (out_free) begin
          state_d = blh_pkg::B_IDLE;
        end
      end
      default: state_d = blh_pkg::B_CLEAR;
    endcase
  end

  // Datapath and state updates
  always_comb begin
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = (rd_data_q == COUNT_MAX) ? rd_data_q : rd_data_q + 1'b1;
    clr_addr_d  = clr_addr_q;
    addr_d      = addr_q;
    ent_d       = ent_q;
    seen_d      = seen_q;
    totals_d    = totals_q;
    short_d     = short_q;
    long_d      = long_q;
    pairs_d     = pairs_q;
    res_status  = blh_pkg::ST_READ;
    res_seen    = 1'b0;
    res_bin_sel = 1'b0;
    res_total   = '0;

    unique case (state_q)
      blh_pkg::B_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
      end
      blh_pkg::B_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o  = 1'b1;
          mem_re = 1'b1;
          ent_d  = head_i;
          addr_d = head_addr;
        end
      end
      blh_pkg::B_EXEC: begin
        if (out_free) begin
          unique case (ent_q.op)
            blh_pkg::OP_SHORT: begin
              short_d    = (short_q == COUNT_MAX) ? short_q : short_q + 1'b1;
              res_status = blh_pkg::ST_TOO_SHORT;
            end
            blh_pkg::OP_LONG: begin
              long_d     = (long_q == COUNT_MAX) ? long_q : long_q + 1'b1;
              res_status = blh_pkg::ST_TOO_LONG;
            end
            blh_pkg::OP_BAD_ELEMENT: begin
              res_status = blh_pkg::ST_BAD_ELEMENT;
            end
            blh_pkg::OP_COUNT: begin
              if (!seen_q[key_idx]) begin
                seen_d[key_idx] = 1'b1;
                if (pairs_q != blh_pkg::PAIRS_MAX) begin
                  pairs_d = pairs_q + 1'b1;
                end
              end
              if (ent_q.type_hit) begin
                mem_we = 1'b1;
                if (totals_q[ent_q.sel_type] != TOTAL_MAX) begin
                  totals_d[ent_q.sel_type] = totals_q[ent_q.sel_type] + 1'b1;
                end
                res_status = blh_pkg::ST_COUNTED;
              end else begin
                res_status = blh_pkg::ST_NO_TYPE;
              end
            end
            blh_pkg::OP_READ: begin
              res_seen    = ent_q.elems_ok && seen_q[key_idx];
              res_bin_sel = ent_q.elems_ok && ent_q.bin_ok;
              res_total   = totals_q[ent_q.sel_type];
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Result assembly
  assign rd_wide    = blh_pkg::WIDE_W'(rd_data_q);
  assign short_wide = blh_pkg::WIDE_W'(short_d);
  assign long_wide  = blh_pkg::WIDE_W'(long_d);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (exec_fire) begin
      out_valid_d            = 1'b1;
      out_d.status           = res_status;
      out_d.bin_count        = res_bin_sel ? rd_wide[blh_pkg::OUT_COUNT_W-1:0] : '0;
      out_d.pair_seen        = res_seen;
      out_d.type_total       = res_total;
      out_d.short_count      = short_wide[blh_pkg::OUT_COUNT_W-1:0];
      out_d.long_count       = long_wide[blh_pkg::OUT_COUNT_W-1:0];
      out_d.pairs_seen_count = pairs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blh_pkg::B_CLEAR;
      clr_addr_q  <= '0;
      seen_q      <= '0;
      for (int i = 0; i < blh_pkg::TYPE_COUNT; i++) begin
        totals_q[i] <= '0;
      end
      short_q     <= '0;
      long_q      <= '0;
      pairs_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      seen_q      <= seen_d;
      totals_q    <= totals_d;
      short_q     <= short_d;
      long_q      <= long_d;
      pairs_q     <= pairs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    addr_q <= addr_d;
    out_q  <= out_d;
  end

  // Histogram store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[head_addr];
    end
  end

  assign clear_busy_o = (state_q == blh_pkg::B_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign out_item_o   = out_q;

  assign pairs_expected = ($countones(seen_q) > int'(blh_pkg::PAIRS_MAX)) ?
                          blh_pkg::PAIRS_MAX : blh_pkg::PAIRS_W'($countones(seen_q));

  `BLH_ASSERT_HOLDS(a_write_only_counted, clk_i, rst_ni,
    mem_we && (state_q != blh_pkg::B_CLEAR),
    (ent_q.op == blh_pkg::OP_COUNT) && ent_q.type_hit,
    "histogram written outside a counted bond")
  `BLH_ASSERT_NEXT(a_clear_runs_to_end, clk_i, rst_ni,
    (state_q == blh_pkg::B_CLEAR) && (clr_addr_q != LAST_ADDR),
    state_q == blh_pkg::B_CLEAR,
    "clearing pass left before the last entry")
  `BLH_ASSERT_HOLDS(a_pairs_match_map, clk_i, rst_ni,
    1'b1, pairs_q == pairs_expected,
    "distinct pair count disagrees with the seen map")
  `BLH_ASSERT_NEXT(a_pop_starts_exec, clk_i, rst_ni,
    pop_o, (state_q == blh_pkg::B_EXEC) && (ent_q == $past(head_i)),
    "popped entry not taken into execution")

endmodule

### rtl/bond_length_histogram_unit.sv
// Bond length histogram unit.
// Input channel (in_valid_i/in_ready_o, in_item_i): one transaction per bond
// record, bin read or counter read; kind three is accepted and dropped.
// Output channel (out_valid_o/out_ready_i, out_item_o): one result per record
// or read, in input order. Registers min/max distance are to be written
// through cfg_we_i/cfg_index_i/cfg_data_i by the user only while the unit is
// idle; the unit does not enforce it. The back end takes no new item before
// the last one is through, as the histogram RAM read is followed by its
// write-back in the execution unit. After reset the histogram RAM is swept to
// zero, one entry a cycle, over all 4 * BIN_COUNT * ELEMENT_LIMIT^2 entries
// (40400 at the defaults); in_ready_o stays low during that sweep. Counters
// and the pair map clear at once.
// A stalled receiver holds the result register; the two-entry queue keeps
// accepting until it is full, then in_ready_o drops.
// ----------------------------------------------------------------------------
// bond_length_histogram_unit
// Top level: front classifier, item queue and execution back end.
// ----------------------------------------------------------------------------
module bond_length_histogram_unit #(
  parameter int unsigned ELEMENT_LIMIT = 10,
  parameter int unsigned BIN_COUNT     = 101,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  blh_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output blh_pkg::out_item_t               out_item_o,
  input  logic                             cfg_we_i,
  input  logic [blh_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [blh_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic               push, pop, clear_busy;
  blh_pkg::q_entry_t  push_entry, head_entry;
  blh_pkg::q_status_t q_status;

  blh_front #(
    .ELEMENT_LIMIT (ELEMENT_LIMIT),
    .BIN_COUNT     (BIN_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .clear_busy_i (clear_busy),
    .q_status_i   (q_status),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  blh_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_status)
  );

  blh_back #(
    .ELEMENT_LIMIT (ELEMENT_LIMIT),
    .BIN_COUNT     (BIN_COUNT),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .head_i       (head_entry),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

### tb/bond_length_histogram_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond length histogram unit test
// Drives bond records, bin reads and counter reads into the unit with
// randomized valid/ready gaps and checks every result against a mirrored
// histogram, reject counters and pair map, across several distance windows.
// ----------------------------------------------------------------------------
module bond_length_histogram_unit_test;

  localparam int unsigned ELEM_LIMIT    = 10;
  localparam int unsigned BINS          = 101;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned SLOTS         = ELEM_LIMIT * ELEM_LIMIT * blh_pkg::TYPE_COUNT * BINS;
  localparam int unsigned MAX_GAP       = 10;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES        = 8;

  localparam bit [3:0] FL_NONE     = 4'b0000;
  localparam bit [3:0] FL_AROMATIC = 4'b1000;
  localparam bit [3:0] FL_SINGLE   = 4'b0100;
  localparam bit [3:0] FL_DOUBLE   = 4'b0010;
  localparam bit [3:0] FL_TRIPLE   = 4'b0001;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  blh_pkg::in_item_t               in_item_i   = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  blh_pkg::out_item_t              out_item_o;
  logic                            cfg_we_i    = 1'b0;
  logic [blh_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [blh_pkg::CFG_DATA_W-1:0]  cfg_data_i  = '0;

  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  bit sink_hold = 1'b0;

  // Mirror of the histogram state; computes the result each transaction causes.
  class histogram_mirror;
    bit [15:0]                 min_dist;
    bit [15:0]                 max_dist;
    bit [COUNT_W-1:0]          bin_tally [SLOTS];
    bit                        pair_marks [ELEM_LIMIT * ELEM_LIMIT];
    bit [blh_pkg::TOTAL_W-1:0] type_sums [blh_pkg::TYPE_COUNT];
    bit [COUNT_W-1:0]          short_rejects;
    bit [COUNT_W-1:0]          long_rejects;
    bit [blh_pkg::PAIRS_W-1:0] pair_tally;
    blh_pkg::out_item_t        awaited_results [$];
    blh_pkg::in_item_t         counted_bonds [$];
    int unsigned               errors;

    function new();
      min_dist = blh_pkg::MIN_DIST_RESET;
      max_dist = blh_pkg::MAX_DIST_RESET;
    endfunction

    function void set_register(blh_pkg::cfg_index_e idx, bit [15:0] value);
      if (idx == blh_pkg::CFG_MIN_DISTANCE) min_dist = value;
      else max_dist = value;
    endfunction

    function void apply_item(blh_pkg::in_item_t it);
      blh_pkg::out_item_t  want;
      blh_pkg::in_item_t   tag;
      int unsigned         ea, eb, key, bin, slot;
      bit                  elems_ok, typed;
      blh_pkg::bond_type_e t;
      if (it.kind == blh_pkg::KIND_IGNORE) return;
      want     = '0;
      ea       = 32'(it.element_a);
      eb       = 32'(it.element_b);
      elems_ok = ea < ELEM_LIMIT && eb < ELEM_LIMIT;
      key      = (ea > eb) ? ELEM_LIMIT * ea + eb : ELEM_LIMIT * eb + ea;
      if (it.kind == blh_pkg::KIND_RECORD) begin
        if (it.distance < min_dist) begin
          if (short_rejects != '1) short_rejects++;
          want.status = blh_pkg::ST_TOO_SHORT;
        end else if (it.distance > max_dist) begin
          if (long_rejects != '1) long_rejects++;
          want.status = blh_pkg::ST_TOO_LONG;
        end else begin
          bin = ((32'(it.distance) - 32'(min_dist)) * blh_pkg::BIN_SCALE) >>
                blh_pkg::FRAC_BITS;
          if (bin >= BINS) begin
            if (long_rejects != '1) long_rejects++;
            want.status = blh_pkg::ST_TOO_LONG;
          end else if (!elems_ok) begin
            want.status = blh_pkg::ST_BAD_ELEMENT;
          end else begin
            if (!pair_marks[key]) begin
              pair_marks[key] = 1'b1;
              if (pair_tally != blh_pkg::PAIRS_MAX) pair_tally++;
            end
            typed = 1'b1;
            t     = blh_pkg::TYPE_AROMATIC;
            if (it.flag_aromatic) t = blh_pkg::TYPE_AROMATIC;
            else if (it.flag_single) t = blh_pkg::TYPE_SINGLE;
            else if (it.flag_double) t = blh_pkg::TYPE_DOUBLE;
            else if (it.flag_triple) t = blh_pkg::TYPE_TRIPLE;
            else typed = 1'b0;
            if (typed) begin
              slot = (key * blh_pkg::TYPE_COUNT + t) * BINS + bin;
              if (bin_tally[slot] != '1) bin_tally[slot]++;
              if (type_sums[t] != '1) type_sums[t]++;
              want.status     = blh_pkg::ST_COUNTED;
              // remember the bin so later reads land on live entries
              tag             = it;
              tag.bin_select  = 7'(bin);
              tag.type_select = t;
              counted_bonds.push_back(tag);
              if (counted_bonds.size() > 64) void'(counted_bonds.pop_front());
            end else begin
              want.status = blh_pkg::ST_NO_TYPE;
            end
          end
        end
      end else begin
        want.status = blh_pkg::ST_READ;
        if (elems_ok) begin
          want.pair_seen = pair_marks[key];
          if (it.bin_select < BINS)
            want.bin_count = bin_tally[(key * blh_pkg::TYPE_COUNT + it.type_select) * BINS
                                       + it.bin_select];
        end
        want.type_total = type_sums[it.type_select];
      end
      want.short_count      = short_rejects;
      want.long_count       = long_rejects;
      want.pairs_seen_count = pair_tally;
      awaited_results.push_back(want);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
    endtask

    task compare_result(blh_pkg::out_item_t got);
      blh_pkg::out_item_t want;
      if (awaited_results.size() == 0) begin
        report("unexpected result, status", 64'(got.status), 64'(0));
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
      if (got.bin_count !== want.bin_count)
        report("bin_count", 64'(got.bin_count), 64'(want.bin_count));
      if (got.pair_seen !== want.pair_seen)
        report("pair_seen", 64'(got.pair_seen), 64'(want.pair_seen));
      if (got.type_total !== want.type_total)
        report("type_total", 64'(got.type_total), 64'(want.type_total));
      if (got.short_count !== want.short_count)
        report("short_count", 64'(got.short_count), 64'(want.short_count));
      if (got.long_count !== want.long_count)
        report("long_count", 64'(got.long_count), 64'(want.long_count));
      if (got.pairs_seen_count !== want.pairs_seen_count)
        report("pairs_seen_count", 64'(got.pairs_seen_count), 64'(want.pairs_seen_count));
    endtask
  endclass

  histogram_mirror mirror;

  bond_length_histogram_unit #(
    .ELEMENT_LIMIT(ELEM_LIMIT),
    .BIN_COUNT    (BINS),
    .COUNT_WIDTH  (COUNT_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int unsigned draw_gap(bit enabled);
    return enabled ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic blh_pkg::in_item_t bond(int unsigned ea, int unsigned eb,
                                             bit [3:0] flags, bit [15:0] bond_len);
    blh_pkg::in_item_t it;
    it           = '0;
    it.kind      = blh_pkg::KIND_RECORD;
    it.element_a = 7'(ea);
    it.element_b = 7'(eb);
    it.distance  = bond_len;
    {it.flag_aromatic, it.flag_single, it.flag_double, it.flag_triple} = flags;
    return it;
  endfunction

  function automatic blh_pkg::in_item_t query(blh_pkg::kind_e kind, int unsigned ea,
                                              int unsigned eb, int unsigned bin,
                                              blh_pkg::bond_type_e t);
    blh_pkg::in_item_t it;
    it             = '0;
    it.kind        = kind;
    it.element_a   = 7'(ea);
    it.element_b   = 7'(eb);
    it.bin_select  = 7'(bin);
    it.type_select = t;
    return it;
  endfunction

  function automatic blh_pkg::in_item_t random_item();
    blh_pkg::in_item_t it;
    blh_pkg::in_item_t tag;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 62) it.kind = blh_pkg::KIND_RECORD;
    else if (pick < 80) it.kind = blh_pkg::KIND_READ_BIN;
    else if (pick < 94) it.kind = blh_pkg::KIND_READ_COUNTERS;
    else it.kind = blh_pkg::KIND_IGNORE;
    it.element_a = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, ELEM_LIMIT - 1));
    it.element_b = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, ELEM_LIMIT - 1));
    if ($urandom_range(0, 3) == 0)
      {it.flag_aromatic, it.flag_single, it.flag_double, it.flag_triple} =
        4'($urandom_range(0, 15));
    else
      {it.flag_aromatic, it.flag_single, it.flag_double, it.flag_triple} =
        FL_AROMATIC >> $urandom_range(0, 3);
    if ($urandom_range(0, 4) != 0 && mirror.min_dist <= mirror.max_dist)
      it.distance = 16'($urandom_range(mirror.min_dist, mirror.max_dist));
    else
      it.distance = 16'($urandom_range(0, 65535));
    it.bin_select  = 7'($urandom_range(0, 127));
    it.type_select = 2'($urandom_range(0, 3));
    if (it.kind != blh_pkg::KIND_RECORD && mirror.counted_bonds.size() != 0
        && $urandom_range(0, 2) != 0) begin
      tag            = mirror.counted_bonds[$urandom_range(0, mirror.counted_bonds.size() - 1)];
      it.element_a   = tag.element_a;
      it.element_b   = tag.element_b;
      it.bin_select  = tag.bin_select;
      it.type_select = tag.type_select;
      if ($urandom_range(0, 1) == 1) begin
        it.element_a = tag.element_b;
        it.element_b = tag.element_a;
      end
    end
    return it;
  endfunction

  task automatic send_item(blh_pkg::in_item_t it);
    int unsigned gap;
    gap = draw_gap(src_idle);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.apply_item(it);
  endtask

  // Drop valid and wait until every result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (mirror.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(blh_pkg::cfg_index_e idx, bit [15:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mirror.set_register(idx, value);
  endtask

  initial begin : result_sink
    int unsigned gap;
    bit          hold_taken;
    hold_taken = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      gap = draw_gap(sink_idle);
      if (sink_hold && !hold_taken) begin
        gap        = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      mirror.compare_result(out_item_o);
    end
  end

  initial begin : stimulus
    blh_pkg::in_item_t directed [$];
    bit [15:0]         phase_min [PHASES];
    bit [15:0]         phase_max [PHASES];
    int unsigned       phase_items [PHASES];
    bit                phase_src_idle [PHASES];
    bit                phase_sink_idle [PHASES];
    int unsigned       span;
    phase_min       = '{16'd0, 16'd4096, 16'd9000, 16'd0, 16'hFFFF, 16'd2048, 16'd0, 16'd12288};
    phase_max       = '{16'hFFFF, 16'd8192, 16'd5000, 16'd0, 16'hFFFF, 16'd2400, 16'd0,
                        16'd16384};
    phase_items     = '{100, 150, 60, 40, 40, 150, 180, 180};
    phase_src_idle  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    phase_sink_idle = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    // one window drawn at random
    phase_min[6] = 16'($urandom_range(0, 60000));
    span         = $urandom_range(0, 4200);
    phase_max[6] = (phase_min[6] + span > 65535) ? 16'hFFFF : 16'(phase_min[6] + span);

    mirror = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // default window is 1.0 to 2.0 angstroms
    directed.push_back(bond(6, 6, FL_AROMATIC, 16'd5734));
    directed.push_back(bond(6, 1, FL_SINGLE, 16'd4506));
    directed.push_back(bond(1, 6, FL_SINGLE, 16'd4506));
    directed.push_back(bond(6, 8, FL_DOUBLE, 16'd4997));
    directed.push_back(bond(7, 6, FL_TRIPLE, 16'd4710));
    directed.push_back(bond(6, 6, 4'b1111, 16'd5734));
    directed.push_back(bond(8, 7, FL_SINGLE | FL_TRIPLE, 16'd6000));
    directed.push_back(bond(6, 7, FL_NONE, 16'd5000));
    directed.push_back(bond(6, 6, FL_SINGLE, 16'd4095));
    directed.push_back(bond(6, 6, FL_SINGLE, 16'd0));
    directed.push_back(bond(6, 6, FL_SINGLE, 16'd8193));
    directed.push_back(bond(6, 6, FL_SINGLE, 16'hFFFF));
    directed.push_back(bond(0, 0, FL_SINGLE, 16'd4096));
    directed.push_back(bond(9, 9, FL_DOUBLE, 16'd8192));
    directed.push_back(bond(10, 6, FL_SINGLE, 16'd5000));
    directed.push_back(bond(127, 127, FL_AROMATIC, 16'd5000));
    directed.push_back(query(blh_pkg::KIND_READ_BIN, 1, 6, 10, blh_pkg::TYPE_SINGLE));
    directed.push_back(query(blh_pkg::KIND_READ_BIN, 6, 6, 39, blh_pkg::TYPE_AROMATIC));
    directed.push_back(query(blh_pkg::KIND_READ_BIN, 9, 9, 100, blh_pkg::TYPE_DOUBLE));
    directed.push_back(query(blh_pkg::KIND_READ_BIN, 6, 1, 127, blh_pkg::TYPE_SINGLE));
    directed.push_back(query(blh_pkg::KIND_READ_BIN, 12, 6, 10, blh_pkg::TYPE_SINGLE));
    directed.push_back(query(blh_pkg::KIND_READ_COUNTERS, 6, 7, 0, blh_pkg::TYPE_TRIPLE));
    directed.push_back(query(blh_pkg::KIND_IGNORE, 6, 6, 39, blh_pkg::TYPE_AROMATIC));
    directed.push_back(query(blh_pkg::KIND_READ_COUNTERS, 0, 0, 0, blh_pkg::TYPE_AROMATIC));
    foreach (directed[i]) send_item(directed[i]);
    settle();

    for (int unsigned p = 0; p < PHASES; p++) begin
      write_register(blh_pkg::CFG_MIN_DISTANCE, phase_min[p]);
      write_register(blh_pkg::CFG_MAX_DISTANCE, phase_max[p]);
      src_idle  = phase_src_idle[p];
      sink_idle = phase_sink_idle[p];
      // stall the output while the input keeps streaming so the queue backs up
      if (p == 1) sink_hold = 1'b1;
      for (int unsigned n = 0; n < phase_items[p]; n++) send_item(random_item());
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.awaited_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/blh_pkg.sv
rtl/blh_queue.sv
rtl/blh_front.sv
rtl/blh_back.sv
rtl/bond_length_histogram_unit.sv
tb/bond_length_histogram_unit_test.sv
